[rtl/pfrt_pkg.sv]
`default_nettype none

package pfrt_pkg;

  // Table geometry and field widths.
  localparam int TABLE_ENTRIES = 64;
  localparam int PID_W         = 16;
  localparam int PAGE_W        = 36;
  localparam int STAMP_W       = 32;
  localparam int CAP_W         = 7;
  localparam int OCC_W         = 7;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W         = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(TABLE_ENTRIES);

  // Item operation codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Item key broadcast to every cell for the whole sweep.
  typedef struct packed {
    op_t                op;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } key_t;

  // Search packet handed from cell to cell.
  typedef struct packed {
    logic               hit;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               min_found;
    logic [IDX_W-1:0]   min_idx;
    logic [STAMP_W-1:0] min_stamp;
    logic [PID_W-1:0]   min_pid;
    logic [PAGE_W-1:0]  min_page;
    logic [CNT_W-1:0]   removed;
  } pkt_t;

  // Slot write broadcast at the end of a load that misses.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

`default_nettype wire

[rtl/page_frame_replacement_table_unit.sv]
`default_nettype none

// Fully associative page-frame table keyed by process id and page number.
// Input channel (in_valid/in_ready): in_op selects a load of in_page_num for
// in_proc_id with stamp in_ref_time, or the end of process in_proc_id.
// Output channel (out_valid/out_ready): one result per item with hit, the
// evicted entry if any, occupancy after the item and the count of entries
// removed by an end-process item.
// cfg_wr_en/cfg_wr_data set the frame capacity; write it only while idle.
// Each item sends a search packet down a chain of TABLE_ENTRIES cells, one
// cell per cycle; the result is decided as the packet leaves the last cell,
// is registered, and is then copied to the output register. The block takes
// no new item until that copy has been made.
// A new item is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result waits inside until the
// output register is free, and the block then takes no further item.
// Reset empties the table, sets the capacity to 64 and drops any result.
module page_frame_replacement_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [pfrt_pkg::PID_W-1:0]    in_proc_id,
  input  wire logic [pfrt_pkg::PAGE_W-1:0]   in_page_num,
  input  wire logic [pfrt_pkg::STAMP_W-1:0]  in_ref_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic                               out_evicted,
  output logic [pfrt_pkg::PID_W-1:0]         out_evicted_pid,
  output logic [pfrt_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [pfrt_pkg::OCC_W-1:0]         out_occupancy,
  output logic [pfrt_pkg::OCC_W-1:0]         out_removed_count,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pfrt_pkg::CAP_W-1:0]    cfg_wr_data
);
  import pfrt_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [PID_W-1:0]  ev_pid;
    logic [PAGE_W-1:0] ev_page;
    logic [CNT_W-1:0]  occ;
    logic [CNT_W-1:0]  removed;
  } res_t;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  key_t               key_r;
  logic               launch_r;
  res_t               res_r, res_nxt;
  logic               out_valid_r;
  res_t               out_r;
  logic               accept;
  logic               out_load;
  logic               exit_vld;
  pkt_t               exit_pk;
  wr_t                wr;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic               room;

  logic [TABLE_ENTRIES:0]      chain_vld;
  pkt_t                        chain_pk [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0]    slot_vld_vec;

  assign accept = in_valid && in_ready;

  // Controller next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (exit_vld) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SWEEP: begin
        in_ready = 1'b0;
      end
      ST_FINISH: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Cell chain; the head packet starts empty.
  assign chain_vld[0] = launch_r;
  assign chain_pk[0]  = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pfrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .key        (key_r),
      .wr         (wr),
      .pk_vld_in  (chain_vld[i]),
      .pk_in      (chain_pk[i]),
      .pk_vld_out (chain_vld[i+1]),
      .pk_out     (chain_pk[i+1]),
      .slot_vld   (slot_vld_vec[i])
    );
  end

  assign exit_vld = chain_vld[TABLE_ENTRIES];
  assign exit_pk  = chain_pk[TABLE_ENTRIES];

  // Usable frames: zero counts as one, values above the table saturate.
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(TABLE_ENTRIES)) begin
      cap_eff = CMP_W'(TABLE_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign room = (CMP_W'(count_r) < cap_eff) && exit_pk.free_found;

  // Decide the item once the packet leaves the last cell.
  always_comb begin
    wr        = '0;
    res_nxt   = '0;
    count_nxt = count_r;
    wr.pid    = key_r.pid;
    wr.page   = key_r.page;
    wr.stamp  = key_r.stamp;
    if (key_r.op == OP_END) begin
      count_nxt       = count_r - exit_pk.removed;
      res_nxt.removed = exit_pk.removed;
    end else if (exit_pk.hit) begin
      res_nxt.hit = 1'b1;
    end else begin
      wr.en = exit_vld;
      if (room) begin
        wr.idx    = exit_pk.free_idx;
        count_nxt = count_r + CNT_W'(1);
      end else if (exit_pk.min_found) begin
        wr.idx          = exit_pk.min_idx;
        res_nxt.evicted = 1'b1;
        res_nxt.ev_pid  = exit_pk.min_pid;
        res_nxt.ev_page = exit_pk.min_page;
      end else begin
        wr.idx    = '0;
        count_nxt = count_r + CNT_W'(1);
      end
    end
    res_nxt.occ = count_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (exit_vld) begin
        count_r <= count_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.op    <= op_t'(in_op);
      key_r.pid   <= in_proc_id;
      key_r.page  <= in_page_num;
      key_r.stamp <= in_ref_time;
    end
    if (exit_vld) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_evicted       = out_r.evicted;
  assign out_evicted_pid   = out_r.ev_pid;
  assign out_evicted_page  = out_r.ev_page;
  assign out_occupancy     = OCC_W'(out_r.occ);
  assign out_removed_count = OCC_W'(out_r.removed);

  // The search packet only reaches the end of the chain during a sweep.
  a_exit_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    exit_vld |-> (state_r == ST_SWEEP))
    else $error("search packet left the chain outside a sweep");

  // Between items the resident count matches the valid slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(slot_vld_vec) == count_r))
    else $error("resident count differs from valid slots");

  // Slots are written only by a load that missed.
  a_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (exit_vld && (key_r.op == OP_LOAD) && !exit_pk.hit))
    else $error("slot write without a load miss");

  // An eviction replaces a resident slot.
  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && res_nxt.evicted) |-> slot_vld_vec[wr.idx])
    else $error("eviction targets an empty slot");

endmodule

`default_nettype wire

[rtl/pfrt_cell.sv]
`default_nettype none

module pfrt_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [pfrt_pkg::IDX_W-1:0] cell_idx,
  input  wire pfrt_pkg::key_t             key,
  input  wire pfrt_pkg::wr_t              wr,
  input  wire logic                       pk_vld_in,
  input  wire pfrt_pkg::pkt_t             pk_in,
  output logic                            pk_vld_out,
  output pfrt_pkg::pkt_t                  pk_out,
  output logic                            slot_vld
);
  import pfrt_pkg::*;

  logic               valid_r, valid_nxt;
  logic [PID_W-1:0]   pid_r;
  logic [PAGE_W-1:0]  page_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               pk_vld_r;
  pkt_t               pk_r, pk_nxt;
  logic               pid_eq;
  logic               page_eq;
  logic               wr_sel;
  logic               flush_me;

  assign pid_eq   = (pid_r == key.pid);
  assign page_eq  = (page_r == key.page);
  assign wr_sel   = wr.en && (wr.idx == cell_idx);
  assign flush_me = pk_vld_in && (key.op == OP_END) && valid_r && pid_eq;

  // Fold this slot into the passing search packet.
  always_comb begin
    pk_nxt = pk_in;
    if (key.op == OP_END) begin
      if (valid_r && pid_eq) begin
        pk_nxt.removed = pk_in.removed + CNT_W'(1);
      end
    end else begin
      if (valid_r && pid_eq && page_eq) begin
        pk_nxt.hit = 1'b1;
      end
      if (!valid_r && !pk_in.free_found) begin
        pk_nxt.free_found = 1'b1;
        pk_nxt.free_idx   = cell_idx;
      end
      // Strict compare keeps the lowest slot on equal stamps.
      if (valid_r && (!pk_in.min_found || (stamp_r < pk_in.min_stamp))) begin
        pk_nxt.min_found = 1'b1;
        pk_nxt.min_idx   = cell_idx;
        pk_nxt.min_stamp = stamp_r;
        pk_nxt.min_pid   = pid_r;
        pk_nxt.min_page  = page_r;
      end
    end
  end

  // The slot is set by a write and cleared when its process ends.
  always_comb begin
    if (wr_sel) begin
      valid_nxt = 1'b1;
    end else if (flush_me) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pk_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      pk_vld_r <= pk_vld_in;
    end
  end

  // Slot contents and packet payload carry no reset.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      pid_r   <= wr.pid;
      page_r  <= wr.page;
      stamp_r <= wr.stamp;
    end
    pk_r <= pk_nxt;
  end

  assign pk_vld_out = pk_vld_r;
  assign pk_out     = pk_r;
  assign slot_vld   = valid_r;

endmodule

`default_nettype wire

[bench/page_frame_replacement_table_unit_test.sv]
`timescale 1ns / 100ps

module page_frame_replacement_table_unit_test;
  import pfrt_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [PID_W-1:0]  evicted_pid;
    logic [PAGE_W-1:0] evicted_page;
    logic [OCC_W-1:0]  occupancy;
    logic [OCC_W-1:0]  removed_count;
  } frame_outcome_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_LOAD;
  logic [PID_W-1:0]    in_proc_id = '0;
  logic [PAGE_W-1:0]   in_page_num = '0;
  logic [STAMP_W-1:0]  in_ref_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic                out_evicted;
  logic [PID_W-1:0]    out_evicted_pid;
  logic [PAGE_W-1:0]   out_evicted_page;
  logic [OCC_W-1:0]    out_occupancy;
  logic [OCC_W-1:0]    out_removed_count;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data = '0;

  page_frame_replacement_table_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_proc_id        (in_proc_id),
    .in_page_num       (in_page_num),
    .in_ref_time       (in_ref_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_evicted       (out_evicted),
    .out_evicted_pid   (out_evicted_pid),
    .out_evicted_page  (out_evicted_page),
    .out_occupancy     (out_occupancy),
    .out_removed_count (out_removed_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the frame table and its capacity register.
  logic               slot_live      [TABLE_ENTRIES];
  logic [PID_W-1:0]   slot_owner     [TABLE_ENTRIES];
  logic [PAGE_W-1:0]  slot_vpage     [TABLE_ENTRIES];
  logic [STAMP_W-1:0] slot_loaded_at [TABLE_ENTRIES];
  int                 resident = 0;
  logic [CAP_W-1:0]   capacity_setting = CAP_RESET;

  key_t               pending_refs[$];
  frame_outcome_t     awaited_outcomes[$];
  key_t               on_port;
  logic [PID_W-1:0]   pid_pool  [6];
  logic [PAGE_W-1:0]  page_pool [32];
  logic [STAMP_W-1:0] wall_clock = '0;

  int gap_left = 0;
  int ready_wait = 0;
  int next_hold_at = 150;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hits_total = 0;
  int evictions_total = 0;
  int exits_total = 0;
  int flushed_total = 0;

  // Apply one page reference or process exit to the shadow table.
  function automatic frame_outcome_t apply_frame_access(input key_t req);
    frame_outcome_t res;
    int target;
    int frames;
    res = '0;
    target = -1;
    if (req.op == OP_END) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_live[i] && slot_owner[i] == req.pid) begin
          slot_live[i] = 1'b0;
          res.removed_count = res.removed_count + 1'b1;
        end
      end
      resident = resident - res.removed_count;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_live[i] && slot_owner[i] == req.pid && slot_vpage[i] == req.page) begin
          res.hit = 1'b1;
        end
      end
      if (!res.hit) begin
        // Capacity zero acts as one frame; anything above the table saturates.
        if (capacity_setting == 0) frames = 1;
        else if (capacity_setting > TABLE_ENTRIES) frames = TABLE_ENTRIES;
        else frames = capacity_setting;
        if (resident < frames) begin
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!slot_live[i]) target = i;
          end
          if (target >= 0) resident++;
        end
        // No free frame: replace the oldest stamp, lowest slot on a tie.
        if (target < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_live[i] && (target < 0 || slot_loaded_at[i] < slot_loaded_at[target])) begin
              target = i;
            end
          end
          if (target >= 0) begin
            res.evicted = 1'b1;
            res.evicted_pid = slot_owner[target];
            res.evicted_page = slot_vpage[target];
          end else begin
            target = 0;
            resident++;
          end
        end
        slot_live[target] = 1'b1;
        slot_owner[target] = req.pid;
        slot_vpage[target] = req.page;
        slot_loaded_at[target] = req.stamp;
      end
    end
    res.occupancy = OCC_W'(resident);
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic queue_load(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                            input logic [STAMP_W-1:0] stamp);
    key_t req;
    req.op = OP_LOAD;
    req.pid = pid;
    req.page = page;
    req.stamp = stamp;
    pending_refs.push_back(req);
  endtask

  task automatic queue_exit(input logic [PID_W-1:0] pid);
    key_t req;
    req.op = OP_END;
    req.pid = pid;
    req.page = PAGE_W'({$urandom, $urandom});
    req.stamp = $urandom;
    pending_refs.push_back(req);
  endtask

  // Random traffic: a few busy processes reusing a page pool, with exits mixed in.
  task automatic queue_random_refs(input int count, input int exit_pct);
    key_t req;
    for (int n = 0; n < count; n++) begin
      req.op = ($urandom_range(99) < exit_pct) ? OP_END : OP_LOAD;
      req.pid = ($urandom_range(9) != 0) ? pid_pool[$urandom_range(5)] : PID_W'($urandom);
      if ($urandom_range(1) == 0) req.page = page_pool[$urandom_range(31)];
      else req.page = PAGE_W'({$urandom, $urandom});
      case ($urandom_range(19))
        0: req.stamp = $urandom;
        1: req.stamp = '0;
        2: req.stamp = '1;
        default: begin
          wall_clock = wall_clock + STAMP_W'($urandom_range(3));
          req.stamp = wall_clock;
        end
      endcase
      pending_refs.push_back(req);
    end
  endtask

  // Wait until the block is empty, then write a new capacity.
  task automatic settle_and_set_capacity(input logic [CAP_W-1:0] value);
    do @(negedge clk);
    while (pending_refs.size() != 0 || in_valid || awaited_outcomes.size() != 0);
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    capacity_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: offers queued references, idling at random between transfers.
  always @(posedge clk) begin : ref_driver
    frame_outcome_t outcome;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        outcome = apply_frame_access(on_port);
        awaited_outcomes.push_back(outcome);
        items_sent++;
        if (outcome.hit) hits_total++;
        if (outcome.evicted) evictions_total++;
        if (on_port.op == OP_END) exits_total++;
        flushed_total += outcome.removed_count;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_refs.size() != 0) begin
          on_port = pending_refs.pop_front();
          in_op <= on_port.op;
          in_proc_id <= on_port.pid;
          in_page_num <= on_port.page;
          in_ref_time <= on_port.stamp;
          in_valid <= 1'b1;
          gap_left <= (((items_sent / 100) % 5) == 3) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, calm stretches and two long holds.
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
    end else if (results_seen >= next_hold_at) begin
      out_ready <= 1'b0;
      ready_wait <= 500;
      next_hold_at <= next_hold_at + 750;
    end else if (ready_wait != 0) begin
      out_ready <= 1'b0;
      ready_wait <= ready_wait - 1;
    end else if (((results_seen / 100) % 5) == 1 || $urandom_range(9) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      ready_wait <= pick_gap();
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    frame_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", 64'd0, 64'd0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_evicted !== want.evicted)
          report_mismatch("evicted", out_evicted, want.evicted);
        if (out_evicted_pid !== want.evicted_pid)
          report_mismatch("evicted_pid", out_evicted_pid, want.evicted_pid);
        if (out_evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", out_evicted_page, want.evicted_page);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", out_occupancy, want.occupancy);
        if (out_removed_count !== want.removed_count)
          report_mismatch("removed_count", out_removed_count, want.removed_count);
      end
    end
  end

  // Stimulus: directed corners first, then random phases at several capacities.
  initial begin : stimulus
    for (int i = 0; i < TABLE_ENTRIES; i++) slot_live[i] = 1'b0;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < 6; i++) pid_pool[i] = PID_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 32; i++) page_pool[i] = PAGE_W'({$urandom, $urandom});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, a hit, a same page under another process, exits.
    queue_load(16'h0000, 36'h0, 32'h0);
    queue_load(16'hFFFF, 36'hF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_load(16'h0000, 36'h0, 32'h5);
    queue_load(16'hFFFF, 36'h0, 32'h1);
    queue_load(16'h0000, 36'hF_FFFF_FFFF, 32'h1);
    queue_load(16'h1234, 36'h5_5555_5555, 32'hAAAA_AAAA);
    queue_exit(16'h0000);
    queue_exit(16'h0000);
    queue_exit(16'h4321);

    // Capacity zero acts as one frame, here already below the occupancy.
    settle_and_set_capacity(7'd0);
    queue_load(16'h0042, 36'hA_AAAA_AAAA, 32'h5555_5555);
    queue_load(16'h0042, 36'h7, 32'h5555_5555);
    queue_load(16'h0042, 36'h7, 32'h0);
    queue_exit(16'hFFFF);
    queue_exit(16'h1234);
    queue_exit(16'h0042);
    queue_load(16'h0001, 36'h1, 32'd10);
    queue_load(16'h0001, 36'h2, 32'd10);

    // Two frames with equal stamps: the lowest slot goes first.
    settle_and_set_capacity(7'd2);
    queue_exit(16'h0001);
    queue_load(16'h0003, 36'h1, 32'd9);
    queue_load(16'h0003, 36'h2, 32'd9);
    queue_load(16'h0003, 36'h3, 32'd9);
    queue_load(16'h0003, 36'h2, 32'd9);

    settle_and_set_capacity(7'd127);
    queue_random_refs(250, 5);
    settle_and_set_capacity(7'd64);
    queue_random_refs(250, 2);
    settle_and_set_capacity(7'd3);
    queue_random_refs(200, 8);
    settle_and_set_capacity(7'd1);
    queue_random_refs(120, 8);
    settle_and_set_capacity(7'd40);
    queue_random_refs(250, 5);
    settle_and_set_capacity(7'd0);
    queue_random_refs(80, 10);
    settle_and_set_capacity(7'd65);
    queue_random_refs(150, 4);

    // Drain, then give any stray result time to show up.
    do @(negedge clk);
    while (pending_refs.size() != 0 || in_valid || awaited_outcomes.size() != 0);
    repeat (80) @(negedge clk);

    $display("tb: %0d references sent (%0d process exits), %0d hits, %0d evictions",
             items_sent, exits_total, hits_total, evictions_total);
    $display("tb: %0d entries flushed, capacities 0 to 127 exercised, %0d mismatches",
             flushed_total, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
rtl/pfrt_pkg.sv
rtl/pfrt_cell.sv
rtl/page_frame_replacement_table_unit.sv
bench/page_frame_replacement_table_unit_test.sv
